// File: hw/rtl/ksr_pkg.sv
// Shared types and codes for the keyed stack with removal.
// Holds request/result payload structs, the queued command type and FSM states.
// No dependencies.
package ksr_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned SHAPE_W     = 8;
  localparam int unsigned LIVE_W      = 6;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    OP_ADD,
    OP_REMOVE
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } back_state_e;

  typedef struct packed {
    logic               req_type;
    logic [KEY_W-1:0]   entry_id;
    logic [SHAPE_W-1:0] shape_code;
    logic               grab_flag;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               show_valid;
    logic [SHAPE_W-1:0] shown_shape;
    logic               shown_grab;
    logic [LIVE_W-1:0]  live_count;
  } rsp_t;

  typedef struct packed {
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [SHAPE_W-1:0] shape;
    logic               grab;
  } cmd_t;

endpackage

// File: hw/rtl/ksr_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port and one read port; no dependencies.
module ksr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ksr_front.sv
// Front end: accepts requests, classifies them into commands and queues them.
// Two-entry queue decouples the input handshake from the table engine.
// Depends on ksr_pkg.
module ksr_front import ksr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;

  always_comb begin
    cmd_in.op    = (in_req_i.req_type == REQ_REMOVE) ? OP_REMOVE : OP_ADD;
    cmd_in.key   = in_req_i.entry_id;
    cmd_in.shape = in_req_i.shape_code;
    cmd_in.grab  = in_req_i.grab_flag;
  end

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: hw/rtl/ksr_back.sv
// Back end: owns the slot table and executes queued commands by scanning it.
// Keeps valid bits in flops and entry data in one ksr_ram; drives the result register.
// Depends on ksr_pkg and ksr_ram.
module ksr_back import ksr_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 32,
  parameter int unsigned ORDER_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IDX_W    = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int unsigned ENTRY_W  = KEY_W + ORDER_BITS + SHAPE_W + 1;
  localparam int unsigned SHAPE_LO = 1;
  localparam int unsigned ORDER_LO = SHAPE_LO + SHAPE_W;
  localparam int unsigned KEY_LO   = ORDER_LO + ORDER_BITS;

  back_state_e state_q, state_d;

  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  eval_q, eval_d;
  logic [IDX_W-1:0]      eval_idx_q, eval_idx_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ORDER_BITS-1:0] order_cnt_q, order_cnt_d;
  cmd_t                  cmd_q, cmd_d;

  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  logic                  free_q, free_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic                  best_q, best_d;
  logic [ORDER_BITS-1:0] best_order_q, best_order_d;
  logic [SHAPE_W-1:0]    best_shape_q, best_shape_d;
  logic                  best_grab_q, best_grab_d;

  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_rsp_q, out_rsp_d;

  logic                  ram_we;
  logic                  ram_re;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic [KEY_W-1:0]      rd_key;
  logic [ORDER_BITS-1:0] rd_order;
  logic [SHAPE_W-1:0]    rd_shape;
  logic                  rd_grab;
  logic                  rd_live;
  logic [CNT_W+LIVE_W-1:0] live_ext;

  assign rd_grab  = ram_rdata[0];
  assign rd_shape = ram_rdata[ORDER_LO-1:SHAPE_LO];
  assign rd_order = ram_rdata[KEY_LO-1:ORDER_LO];
  assign rd_key   = ram_rdata[ENTRY_W-1:KEY_LO];
  assign rd_live  = valid_q[eval_idx_q];

  assign ram_re    = (state_q == S_SCAN) && (idx_q < CNT_W'(SLOT_COUNT));
  assign ram_wdata = {cmd_q.key, order_cnt_q, cmd_q.shape, cmd_q.grab};

  ksr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    eval_d       = 1'b0;
    eval_idx_d   = eval_idx_q;
    count_d      = count_q;
    order_cnt_d  = order_cnt_q;
    cmd_d        = cmd_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    best_d       = best_q;
    best_order_d = best_order_q;
    best_shape_d = best_shape_q;
    best_grab_d  = best_grab_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_rsp_d    = out_rsp_q;
    cmd_ready_o  = 1'b0;
    ram_we       = 1'b0;
    live_ext     = '0;

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          idx_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          best_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ram_re) begin
          eval_d     = 1'b1;
          eval_idx_d = idx_q[IDX_W-1:0];
          idx_d      = idx_q + CNT_W'(1);
        end else if (!eval_q) begin
          state_d = S_DONE;
        end
        if (eval_q) begin
          if (rd_live && (rd_key == cmd_q.key)) begin
            hit_d     = 1'b1;
            hit_idx_d = eval_idx_q;
          end else if (rd_live) begin
            if (!best_q || (rd_order > best_order_q)) begin
              best_d       = 1'b1;
              best_order_d = rd_order;
              best_shape_d = rd_shape;
              best_grab_d  = rd_grab;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = eval_idx_q;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_rsp_d.show_valid  = 1'b0;
          out_rsp_d.shown_shape = '0;
          out_rsp_d.shown_grab  = 1'b0;
          if (cmd_q.op == OP_ADD) begin
            if (hit_q) begin
              out_rsp_d.status = ST_DUPLICATE;
            end else if (!free_q) begin
              out_rsp_d.status = ST_FULL;
            end else begin
              ram_we                = 1'b1;
              valid_d[free_idx_q]   = 1'b1;
              order_cnt_d           = order_cnt_q + ORDER_BITS'(1);
              count_d               = count_q + CNT_W'(1);
              out_rsp_d.status      = ST_ADDED;
              out_rsp_d.show_valid  = 1'b1;
              out_rsp_d.shown_shape = cmd_q.shape;
              out_rsp_d.shown_grab  = cmd_q.grab;
            end
          end else begin
            if (!hit_q) begin
              out_rsp_d.status = ST_NOT_FOUND;
            end else begin
              valid_d[hit_idx_q] = 1'b0;
              if (count_q != '0) begin
                count_d = count_q - CNT_W'(1);
              end
              out_rsp_d.status = ST_REMOVED;
              if (best_q) begin
                out_rsp_d.show_valid  = 1'b1;
                out_rsp_d.shown_shape = best_shape_q;
                out_rsp_d.shown_grab  = best_grab_q;
              end
            end
          end
          live_ext             = {{LIVE_W{1'b0}}, count_d};
          out_rsp_d.live_count = live_ext[LIVE_W-1:0];
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      idx_q       <= '0;
      eval_q      <= 1'b0;
      count_q     <= '0;
      order_cnt_q <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      best_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      idx_q       <= idx_d;
      eval_q      <= eval_d;
      count_q     <= count_d;
      order_cnt_q <= order_cnt_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q   <= eval_idx_d;
    cmd_q        <= cmd_d;
    hit_idx_q    <= hit_idx_d;
    free_idx_q   <= free_idx_d;
    best_order_q <= best_order_d;
    best_shape_q <= best_shape_d;
    best_grab_q  <= best_grab_d;
    out_rsp_q    <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: hw/rtl/keyed_stack_with_removal.sv
// Keyed stack with removal: a table of SLOT_COUNT keyed entries whose top is the entry with
// the highest sequence stamp. An add takes the lowest free slot unless its key is present or
// the table is full; a remove frees the matching entry and reports the new top entry. Each
// request yields exactly one result. A request passes through the two-entry request queue
// into the table engine, which scans the slot memory one slot per cycle on its single read
// port and takes the next request only once it has written the result. Up to two requests
// wait in the queue while a result is held in the output register.
// Depends on ksr_pkg, ksr_front and ksr_back.
module keyed_stack_with_removal import ksr_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 32,
  parameter int unsigned ORDER_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  ksr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  ksr_back #(
    .SLOT_COUNT(SLOT_COUNT),
    .ORDER_BITS(ORDER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for keyed_stack_with_removal; depends on ksr_pkg and its RTL.
// Directed rows are checked against their fixed expected results (the predictor where none is
// given), then random fill, drain and mixed phases against an in-bench table predictor.
`timescale 1ns / 1ps

module tb_top;
  import ksr_pkg::*;

  localparam int unsigned SLOTS       = 32;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned RAND_ITEMS  = 650;
  localparam int unsigned MAX_GAP     = 18;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned SETTLE      = 2 * SLOTS + 8;
  localparam int unsigned DIR_ROWS    = 18;

  localparam rsp_t NO_RSP = '0;

  typedef struct packed {
    req_t req;
    logic fixed;
    rsp_t rsp;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  logic               tbl_used  [SLOTS];
  logic [KEY_W-1:0]   tbl_key   [SLOTS];
  logic [STAMP_W-1:0] tbl_stamp [SLOTS];
  logic [SHAPE_W-1:0] tbl_shape [SLOTS];
  logic               tbl_grab  [SLOTS];
  logic [STAMP_W-1:0] stamp_next;
  int unsigned        used_count;

  rsp_t        pending_rsp [$];
  int unsigned errors = 0;
  int unsigned idle_cycles;
  bit          send_burst;

  row_t directed_rows [DIR_ROWS] = '{
    {{REQ_ADD,    32'h0000_0000, 8'h00, 1'b0}, 1'b1, {ST_ADDED,     1'b1, 8'h00, 1'b0, 6'd1}},
    {{REQ_ADD,    32'hFFFF_FFFF, 8'hFF, 1'b1}, 1'b1, {ST_ADDED,     1'b1, 8'hFF, 1'b1, 6'd2}},
    {{REQ_ADD,    32'h0000_0000, 8'h12, 1'b1}, 1'b1, {ST_DUPLICATE, 1'b0, 8'h00, 1'b0, 6'd2}},
    {{REQ_REMOVE, 32'h1234_5678, 8'hFF, 1'b1}, 1'b1, {ST_NOT_FOUND, 1'b0, 8'h00, 1'b0, 6'd2}},
    {{REQ_ADD,    32'hA5A5_A5A5, 8'h5A, 1'b0}, 1'b1, {ST_ADDED,     1'b1, 8'h5A, 1'b0, 6'd3}},
    {{REQ_REMOVE, 32'hFFFF_FFFF, 8'h00, 1'b0}, 1'b1, {ST_REMOVED,   1'b1, 8'h5A, 1'b0, 6'd2}},
    {{REQ_ADD,    32'h5A5A_5A5A, 8'h81, 1'b1}, 1'b1, {ST_ADDED,     1'b1, 8'h81, 1'b1, 6'd3}},
    {{REQ_REMOVE, 32'h5A5A_5A5A, 8'h00, 1'b0}, 1'b1, {ST_REMOVED,   1'b1, 8'h5A, 1'b0, 6'd2}},
    {{REQ_REMOVE, 32'hA5A5_A5A5, 8'h00, 1'b0}, 1'b1, {ST_REMOVED,   1'b1, 8'h00, 1'b0, 6'd1}},
    {{REQ_REMOVE, 32'h0000_0000, 8'h00, 1'b0}, 1'b1, {ST_REMOVED,   1'b0, 8'h00, 1'b0, 6'd0}},
    {{REQ_REMOVE, 32'h0000_0000, 8'h00, 1'b0}, 1'b1, {ST_NOT_FOUND, 1'b0, 8'h00, 1'b0, 6'd0}},
    {{REQ_ADD,    32'hFFFF_FFFF, 8'h7F, 1'b0}, 1'b1, {ST_ADDED,     1'b1, 8'h7F, 1'b0, 6'd1}},
    {{REQ_ADD,    32'h8000_0000, 8'h80, 1'b1}, 1'b1, {ST_ADDED,     1'b1, 8'h80, 1'b1, 6'd2}},
    {{REQ_ADD,    32'h0000_0001, 8'h01, 1'b0}, 1'b0, NO_RSP},
    {{REQ_REMOVE, 32'h8000_0000, 8'hC3, 1'b1}, 1'b0, NO_RSP},
    {{REQ_ADD,    32'hFFFF_FFFF, 8'hFF, 1'b1}, 1'b1, {ST_DUPLICATE, 1'b0, 8'h00, 1'b0, 6'd2}},
    {{REQ_REMOVE, 32'h0000_0001, 8'h3C, 1'b0}, 1'b0, NO_RSP},
    {{REQ_REMOVE, 32'hFFFF_FFFF, 8'h00, 1'b0}, 1'b1, {ST_REMOVED,   1'b0, 8'h00, 1'b0, 6'd0}}
  };

  keyed_stack_with_removal #(
    .SLOT_COUNT(SLOTS),
    .ORDER_BITS(STAMP_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic rsp_t table_step(req_t r);
    rsp_t res;
    int   hit;
    int   free_idx;
    int   top;
    res      = NO_RSP;
    hit      = -1;
    free_idx = -1;
    top      = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && tbl_used[i] && tbl_key[i] == r.entry_id) hit = i;
      if (free_idx < 0 && !tbl_used[i]) free_idx = i;
    end
    if (r.req_type == REQ_ADD) begin
      if (hit >= 0) begin
        res.status = ST_DUPLICATE;
      end else if (free_idx < 0) begin
        res.status = ST_FULL;
      end else begin
        tbl_used[free_idx]  = 1'b1;
        tbl_key[free_idx]   = r.entry_id;
        tbl_stamp[free_idx] = stamp_next;
        tbl_shape[free_idx] = r.shape_code;
        tbl_grab[free_idx]  = r.grab_flag;
        stamp_next          = stamp_next + 1'b1;
        used_count++;
        res.status      = ST_ADDED;
        res.show_valid  = 1'b1;
        res.shown_shape = r.shape_code;
        res.shown_grab  = r.grab_flag;
      end
    end else if (hit < 0) begin
      res.status = ST_NOT_FOUND;
    end else begin
      tbl_used[hit] = 1'b0;
      if (used_count > 0) used_count--;
      res.status = ST_REMOVED;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_used[i] && (top < 0 || tbl_stamp[i] > tbl_stamp[top])) top = i;
      end
      if (top >= 0) begin
        res.show_valid  = 1'b1;
        res.shown_shape = tbl_shape[top];
        res.shown_grab  = tbl_grab[top];
      end
    end
    res.live_count = LIVE_W'(used_count);
    return res;
  endfunction

  function automatic bit live_key(output logic [KEY_W-1:0] key);
    int unsigned start;
    start = $urandom_range(0, SLOTS - 1);
    key   = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (tbl_used[(start + k) % SLOTS]) begin
        key = tbl_key[(start + k) % SLOTS];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic req_t rand_req(int unsigned add_pct);
    req_t             r;
    logic [KEY_W-1:0] k;
    r.entry_id   = $urandom;
    r.shape_code = SHAPE_W'($urandom_range(0, 255));
    r.grab_flag  = 1'($urandom_range(0, 1));
    r.req_type   = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_REMOVE;
    if (r.req_type == REQ_ADD) begin
      if ($urandom_range(0, 99) < 12 && live_key(k)) r.entry_id = k;
    end else if ($urandom_range(0, 99) < 88 && live_key(k)) begin
      r.entry_id = k;
    end
    return r;
  endfunction

  task automatic push_req(input req_t r, input logic fixed, input rsp_t want);
    int unsigned gap;
    rsp_t        predicted;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = table_step(r);
    pending_rsp.push_back(fixed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_rsp.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_rsp
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected item: status %0d", out_rsp_o.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", want.status, out_rsp_o.status);
        check_field("show_valid", want.show_valid, out_rsp_o.show_valid);
        check_field("shown_shape", want.shown_shape, out_rsp_o.shown_shape);
        check_field("shown_grab", want.shown_grab, out_rsp_o.shown_grab);
        check_field("live_count", want.live_count, out_rsp_o.live_count);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL keyed_stack_with_removal");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : drain_rsp
    int unsigned gap;
    int unsigned taken;
    bit          burst;
    out_ready_i = 1'b0;
    taken       = 0;
    burst       = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned add_pct;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    send_burst  = 1'b0;
    stamp_next  = '0;
    used_count  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_key[i]   = '0;
      tbl_stamp[i] = '0;
      tbl_shape[i] = '0;
      tbl_grab[i]  = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int n = 0; n < DIR_ROWS; n++) begin
      push_req(directed_rows[n].req, directed_rows[n].fixed, directed_rows[n].rsp);
    end
    wait_drained();

    // fill toward full, drain toward empty, then mix
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      case (phase % 3)
        0:       add_pct = 90;
        1:       add_pct = 15;
        default: add_pct = 50;
      endcase
      send_burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 50 && sent < RAND_ITEMS; n++) begin
        push_req(rand_req(add_pct), 1'b0, NO_RSP);
        sent++;
      end
      if (phase == 4) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("PASS keyed_stack_with_removal");
    end else begin
      $display("FAIL keyed_stack_with_removal");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ksr_pkg.sv
hw/rtl/ksr_ram.sv
hw/rtl/ksr_front.sv
hw/rtl/ksr_back.sv
hw/rtl/keyed_stack_with_removal.sv
tb/sv/tb_top.sv
